// File: rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, cell command and cell status types shared by the cache core.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkv_state_e;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic              lookup;    // capture first-hit flag
    logic              update;    // apply the operation
    logic              put;       // operation is a put
    logic              found;     // lookup hit
    logic              evict;     // put miss with the store full
    logic [OCC_W-1:0]  keep;      // ranks below this survive eviction
    logic [RANK_W-1:0] hit_rank;  // rank of the hit cell
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } lkv_cmd_t;

  // Status reported by one cell
  typedef struct packed {
    logic              valid;
    logic              first_hit;  // this cell is the lowest matching cell
    logic [RANK_W-1:0] rank;       // zero unless first_hit
    logic [VAL_W-1:0]  value;      // zero unless first_hit
  } lkv_cell_st_t;

endpackage

// File: rtl/core/lkv_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkv_in_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lkv_out_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] value_out;

  modport source (output valid, found, value_out, input ready);
  modport sink   (input valid, found, value_out, output ready);
endinterface

// File: rtl/core/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative store built as a row of cells with LRU replacement.
// ----------------------------------------------------------------------------
// Flow: a get passes the lookup state and then the update state, where its
//   result is registered. Each item is a parallel compare in all cells, then
//   an update; a new request is taken only as the last one finishes, and a get
//   stalls only while the response register is still full.
// Reset: valid flags, ranks, occupancy and control clear at once; capacity
//   resets to the full entry count. No clearing pass.
module lru_key_value_cache_core import lkv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  lkv_in_if.sink           in_i,
  lkv_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i
);

  lkv_state_e state_q, state_d;

  logic [CAP_W-1:0]  capacity_q;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  value_q;
  logic              found_q;
  logic [RANK_W-1:0] hit_rank_q;
  logic [VAL_W-1:0]  hit_value_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [VAL_W-1:0]  out_value_q;

  logic [OCC_W-1:0]  cap_used, keep;
  logic              evict, can_finish, finish, accept;
  logic              any_hit;
  logic [RANK_W-1:0] hit_rank;
  logic [VAL_W-1:0]  hit_value;
  logic [ENTRIES-1:0] valid_vec, hit_vec;

  lkv_cmd_t     cmd;
  lkv_cell_st_t cell_st [ENTRIES];
  logic [ENTRIES:0] hit_chain, free_chain;

  // Clamp capacity to 1..ENTRIES
  always_comb begin
    if (capacity_q == '0) begin
      cap_used = OCC_W'(1);
    end else if (32'(capacity_q) > 32'(ENTRIES)) begin
      cap_used = OCC_W'(ENTRIES);
    end else begin
      cap_used = OCC_W'(capacity_q);
    end
  end

  assign keep  = cap_used - OCC_W'(1);
  assign evict = (occ_q >= cap_used);

  assign can_finish = mode_q || !out_valid_q || out_o.ready;
  assign finish     = (state_q == ST_UPDATE) && can_finish;
  assign in_i.ready = (state_q == ST_IDLE) || finish;
  assign accept     = in_i.valid && in_i.ready;

  assign cmd.lookup   = (state_q == ST_LOOKUP);
  assign cmd.update   = finish;
  assign cmd.put      = mode_q;
  assign cmd.found    = found_q;
  assign cmd.evict    = mode_q && !found_q && evict;
  assign cmd.keep     = keep;
  assign cmd.hit_rank = hit_rank_q;
  assign cmd.key      = key_q;
  assign cmd.value    = value_q;

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .hit_seen_i  (hit_chain[g]),
      .hit_seen_o  (hit_chain[g+1]),
      .free_seen_i (free_chain[g]),
      .free_seen_o (free_chain[g+1]),
      .st_o        (cell_st[g])
    );
    assign valid_vec[g] = cell_st[g].valid;
    assign hit_vec[g]   = cell_st[g].first_hit;
  end

  // Gather the hit cell's rank and value
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank | cell_st[i].rank;
      hit_value = hit_value | cell_st[i].value;
    end
  end
  assign any_hit = hit_chain[ENTRIES];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (finish) begin
          state_d = accept ? ST_LOOKUP : ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (finish && mode_q && !found_q) begin
      occ_d = evict ? keep + OCC_W'(1) : occ_q + OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      capacity_q  <= CAP_W'(16);
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
      end
      // load on a finished get, drop on transfer
      if (finish && !mode_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_i.mode;
      key_q   <= in_i.key;
      value_q <= in_i.value;
    end
    if (state_q == ST_LOOKUP) begin
      found_q     <= any_hit;
      hit_rank_q  <= hit_rank;
      hit_value_q <= hit_value;
    end
    if (finish && !mode_q) begin
      out_found_q <= found_q;
      out_value_q <= found_q ? hit_value_q : '1;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.found     = out_found_q;
  assign out_o.value_out = out_value_q;

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(ENTRIES))
    else $error("occupancy exceeds entry count");

  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(occ_q))
    else $error("occupancy does not match valid cells");

  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one first hit");

  a_put_no_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && mode_q && !out_valid_q) |=> !out_valid_q)
    else $error("put produced a response");
`endif

endmodule

// File: rtl/core/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One entry: key, value, valid and recency rank. Passes first-hit and
// first-free flags down the row to its neighbor.
// ----------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lkv_cmd_t     cmd_i,
  input  logic         hit_seen_i,
  output logic         hit_seen_o,
  input  logic         free_seen_i,
  output logic         free_seen_o,
  output lkv_cell_st_t st_o
);

  logic [KEY_W-1:0]  key_q, key_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic              valid_q, valid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              hit_q, hit_d;

  logic match, first_hit, evicted, free, take;

  assign match       = valid_q && (key_q == cmd_i.key);
  assign first_hit   = match && !hit_seen_i;
  assign hit_seen_o  = hit_seen_i | match;

  assign evicted     = cmd_i.evict && valid_q && (OCC_W'(rank_q) >= cmd_i.keep);
  assign free        = !valid_q || evicted;
  assign take        = free && !free_seen_i;
  assign free_seen_o = free_seen_i | free;

  assign st_o.valid     = valid_q;
  assign st_o.first_hit = first_hit;
  assign st_o.rank      = first_hit ? rank_q : '0;
  assign st_o.value     = first_hit ? value_q : '0;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    hit_d   = hit_q;
    if (cmd_i.lookup) begin
      hit_d = first_hit;
    end
    if (cmd_i.update) begin
      if (cmd_i.found) begin
        // promote the hit cell, age the more recent ones
        if (hit_q) begin
          rank_d = '0;
          if (cmd_i.put) begin
            value_d = cmd_i.value;
          end
        end else if (valid_q && (rank_q < cmd_i.hit_rank)) begin
          rank_d = rank_q + RANK_W'(1);
        end
      end else if (cmd_i.put) begin
        if (take) begin
          key_d   = cmd_i.key;
          value_d = cmd_i.value;
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (evicted) begin
          valid_d = 1'b0;
        end else if (valid_q) begin
          rank_d = rank_q + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule
